>>> sv/balu_pkg.sv
// Package for the byte ALU: command, CB group and shift codes, stream widths
// and the registered payload structures. No dependencies.
package balu_pkg;

  // Stream widths: tdata is padded up to whole bytes.
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned M_TUSER_W = 1;

  // Bit positions inside a flag nibble.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef enum logic [2:0] {
    CMD_CB  = 3'd0,
    CMD_ADD = 3'd1,
    CMD_XOR = 3'd2,
    CMD_CP  = 3'd3,
    CMD_INC = 3'd4,
    CMD_DEC = 3'd5,
    CMD_RLA = 3'd6,
    CMD_CPL = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    CB_SHIFT = 2'd0,
    CB_BIT   = 2'd1,
    CB_RES   = 2'd2,
    CB_SET   = 2'd3
  } cb_grp_e;

  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] cb_opcode;
    logic [7:0] accumulator;
    logic [7:0] operand;
    logic [3:0] flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       write_result;
  } alu_out_t;

endpackage

>>> sv/byte_alu_with_bit_ops_top.sv
// Byte ALU with CB rotate, shift and bit operations behind stream ports.
// Depends on balu_pkg.
// An accepted input beat is held in the input register, then in the result register, before it leaves as a result beat.
// Throughput: one beat per cycle, set by the single-pass ALU between the
// input register and the result register; a stalled full result stage holds
// both stages, while an empty stage still fills.
// Reset clears both stage valid bits; payload registers are not reset.
module byte_alu_with_bit_ops_top import balu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: cb_opcode[7:0], accumulator[7:0], operand[7:0],
  // flags_in[3:0], zero padding[3:0].
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: command[2:0].
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0: result[7:0], flags_out[3:0], zero padding[3:0].
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: write_result.
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  logic     in_vld_q;
  alu_in_t  in_q;
  logic     out_vld_q;
  alu_out_t out_q;
  alu_out_t alu_d;
  logic     out_adv;
  logic     in_adv;

  // The result stage can take a new value when it is empty or draining.
  assign out_adv       = !out_vld_q || m_axis_tready;
  assign in_adv        = !in_vld_q || out_adv;
  assign s_axis_tready = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      in_q.command     <= s_axis_tuser[2:0];
      in_q.cb_opcode   <= s_axis_tdata[7:0];
      in_q.accumulator <= s_axis_tdata[15:8];
      in_q.operand     <= s_axis_tdata[23:16];
      in_q.flags_in    <= s_axis_tdata[27:24];
    end
    if (out_adv && in_vld_q) begin
      out_q <= alu_d;
    end
  end

  logic [7:0] a;
  logic [7:0] v;
  logic [3:0] fin;
  logic       cin;
  logic [2:0] kind;
  logic [8:0] sum;
  logic [4:0] half_sum;
  logic [7:0] diff;
  logic [7:0] bit_mask;
  logic [7:0] sh_res;
  logic       sh_c;

  assign a        = in_q.accumulator;
  assign v        = in_q.operand;
  assign fin      = in_q.flags_in;
  assign cin      = fin[FLAG_C];
  assign kind     = in_q.cb_opcode[5:3];
  assign sum      = {1'b0, a} + {1'b0, v};
  assign half_sum = {1'b0, a[3:0]} + {1'b0, v[3:0]};
  assign diff     = a - v;
  assign bit_mask = 8'h01 << kind;

  always_comb begin
    case (shift_e'(kind))
      SH_RLC:  begin sh_res = {v[6:0], v[7]};  sh_c = v[7]; end
      SH_RRC:  begin sh_res = {v[0], v[7:1]};  sh_c = v[0]; end
      SH_RL:   begin sh_res = {v[6:0], cin};   sh_c = v[7]; end
      SH_RR:   begin sh_res = {cin, v[7:1]};   sh_c = v[0]; end
      SH_SLA:  begin sh_res = {v[6:0], 1'b0};  sh_c = v[7]; end
      SH_SRA:  begin sh_res = {v[7], v[7:1]};  sh_c = v[0]; end
      SH_SWAP: begin sh_res = {v[3:0], v[7:4]}; sh_c = 1'b0; end
      default: begin sh_res = {1'b0, v[7:1]};  sh_c = v[0]; end
    endcase
  end

  always_comb begin
    alu_d.result       = a;
    alu_d.flags_out    = fin;
    alu_d.write_result = 1'b1;
    unique case (cmd_e'(in_q.command))
      CMD_CB: begin
        unique case (cb_grp_e'(in_q.cb_opcode[7:6]))
          CB_BIT: begin
            alu_d.result       = v;
            alu_d.write_result = 1'b0;
            alu_d.flags_out    = {((v & bit_mask) == 8'h00), 1'b0, 1'b1, cin};
          end
          CB_RES: begin
            alu_d.result    = v & ~bit_mask;
            alu_d.flags_out = fin;
          end
          CB_SET: begin
            alu_d.result    = v | bit_mask;
            alu_d.flags_out = fin;
          end
          default: begin
            alu_d.result    = sh_res;
            alu_d.flags_out = {(sh_res == 8'h00), 1'b0, 1'b0, sh_c};
          end
        endcase
      end
      CMD_ADD: begin
        alu_d.result    = sum[7:0];
        alu_d.flags_out = {(sum[7:0] == 8'h00), 1'b0, half_sum[4], sum[8]};
      end
      CMD_XOR: begin
        alu_d.result    = a ^ v;
        alu_d.flags_out = {((a ^ v) == 8'h00), 3'b000};
      end
      CMD_CP: begin
        // The accumulator passes through; only the flags of a - v count.
        alu_d.result       = a;
        alu_d.write_result = 1'b0;
        alu_d.flags_out    = {(diff == 8'h00), 1'b1, (a[3:0] < v[3:0]), (a < v)};
      end
      CMD_INC: begin
        alu_d.result    = v + 8'h01;
        alu_d.flags_out = {(v == 8'hFF), 1'b0, (v[3:0] == 4'hF), cin};
      end
      CMD_DEC: begin
        alu_d.result    = v - 8'h01;
        alu_d.flags_out = {(v == 8'h01), 1'b1, (v[3:0] == 4'h0), cin};
      end
      CMD_RLA: begin
        alu_d.result    = {a[6:0], cin};
        alu_d.flags_out = {3'b000, a[7]};
      end
      default: begin
        alu_d.result    = ~a;
        alu_d.flags_out = {fin[FLAG_Z], 1'b1, 1'b1, fin[FLAG_C]};
      end
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'h0, out_q.flags_out, out_q.result};
  assign m_axis_tuser  = out_q.write_result;

endmodule

>>> sv/balu_checker.sv
// Port-level checker for the byte ALU, bound to the top level.
// Depends on balu_pkg.
module balu_checker import balu_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // The input side only stalls when the result stage is full and blocked.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without backpressure");

  // An accepted beat reaches the output when the sink is ready while the beat sits in the input stage.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat did not reach the output");

  // Beats without write-back are BIT (H set) or compare (N set).
  a_nowrite_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == 1'b0) |->
      m_axis_tdata[8 + FLAG_N] || m_axis_tdata[8 + FLAG_H])
    else $error("no-write beat with unexpected flags");

endmodule

bind byte_alu_with_bit_ops_top balu_checker u_balu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
